### hdl/ordered_list_compare_remove_assert.svh
// Assertion macros used by the ordered list top-level RTL file.
`ifndef ORDERED_LIST_COMPARE_REMOVE_ASSERT_SVH
`define ORDERED_LIST_COMPARE_REMOVE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define OLCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define OLCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/olcr_pkg.sv
// Shared types, codes and compare function of the ordered list block.
package olcr_pkg;

  localparam int DEPTH_DEF = 16;

  // Action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Compare modes for removal
  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] operand_value;
    logic [1:0]         compare_mode;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic       overflow;
    logic [4:0] entry_count;
    logic       is_empty;
  } out_item_t;

  // Broadcast control from the controller to every cell
  typedef struct packed {
    logic               shift;
    logic               remove;
    logic [1:0]         mode;
    logic signed [31:0] operand;
  } cell_ctl_t;

  // Entry against operand under a compare mode; unused mode never matches.
  function automatic logic entry_match(input logic signed [31:0] e,
                                       input logic signed [31:0] v,
                                       input logic [1:0] mode);
    logic m;
    unique case (mode)
      CMP_LT:  m = (e < v);
      CMP_EQ:  m = (e == v);
      CMP_GT:  m = (e > v);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

### hdl/olcr_cell.sv
// One list slot: stored value, scan token and found flag passed to the next slot.
module olcr_cell #(
  parameter int DEPTH = olcr_pkg::DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  olcr_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]       count,
  input  logic signed [31:0]  left_val,
  input  logic signed [31:0]  right_val,
  input  logic                tok_i,
  input  logic                found_i,
  output logic signed [31:0]  val_o,
  output logic                tok_o,
  output logic                found_o
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic signed [31:0] val_r, val_nxt;
  logic               tok_r, found_r;
  logic               occ, match, take_right;

  // Compare own value while the slot holds a live entry
  assign occ        = (IDX_C < count);
  assign match      = occ && olcr_pkg::entry_match(val_r, ctl.operand, ctl.mode);
  assign take_right = tok_r && ctl.remove && (found_r || match);

  // Shift back on insert, pull forward from or past the removed slot
  always_comb begin
    if (ctl.shift) begin
      val_nxt = left_val;
    end else if (take_right) begin
      val_nxt = right_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    found_r <= found_i;
  end

  // Advance the token one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  assign val_o   = val_r;
  assign tok_o   = tok_r;
  assign found_o = found_r || match;

endmodule

### hdl/ordered_list_compare_remove.sv
// Top level of the bounded ordered list: controller and chain of slot cells.
//
//  channel   ports                       handshake
//  input     start, busy, in_item        taken when start and !busy
//  result    out_strobe, out_item        one cycle per result, no stall
//
// Insert and unused actions: result in the cycle after acceptance, busy stays low,
// so such items may be accepted every cycle.
// Query and removal: a token walks the chain one slot per cycle, and the result
// shows once the token has left the tail slot; busy drops as the result appears,
// so the next item can be taken at the edge that ends the result.
// Reset (synchronous, rst_n low) empties the list; slot values are not cleared.
// The receiver cannot stall; every result shows for exactly one cycle.
module ordered_list_compare_remove #(
  parameter int DEPTH = olcr_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  olcr_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output olcr_pkg::out_item_t out_item
);

  `include "ordered_list_compare_remove_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic                busy_r, busy_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic signed [31:0]  op_r, op_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic                rm_r, rm_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  olcr_pkg::out_item_t out_item_r, out_item_nxt;

  logic                accept, ins_ok, scan_go;
  olcr_pkg::cell_ctl_t ctl;

  logic signed [31:0]  cval [DEPTH];
  logic                tk   [DEPTH+1];
  logic                fd   [DEPTH+1];

  assign accept  = start && !busy_r;
  assign ins_ok  = accept && (in_item.action == olcr_pkg::ACT_INSERT) && (count_r != FULL);
  assign scan_go = accept && ((in_item.action == olcr_pkg::ACT_QUERY) ||
                              (in_item.action == olcr_pkg::ACT_REMOVE));

  // Broadcast control to the cells
  assign ctl.shift   = ins_ok;
  assign ctl.remove  = rm_r;
  assign ctl.mode    = mode_r;
  assign ctl.operand = op_r;

  // Launch the token into the head slot
  assign tk[0] = scan_go;
  assign fd[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lv, rv;
    if (i == 0) begin : g_head
      assign lv = in_item.operand_value;
    end else begin : g_mid
      assign lv = cval[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = cval[i];
    end else begin : g_body
      assign rv = cval[i+1];
    end
    olcr_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count_r),
      .left_val  (lv),
      .right_val (rv),
      .tok_i     (tk[i]),
      .found_i   (fd[i]),
      .val_o     (cval[i]),
      .tok_o     (tk[i+1]),
      .found_o   (fd[i+1])
    );
  end

  // Accept items, finish scans when the token leaves the tail
  always_comb begin
    busy_nxt       = busy_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    mode_nxt       = mode_r;
    rm_nxt         = rm_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    out_item_nxt.hit      = 1'b0;
    out_item_nxt.overflow = 1'b0;
    if (accept) begin
      unique case (in_item.action)
        olcr_pkg::ACT_INSERT: begin
          out_strobe_nxt        = 1'b1;
          out_item_nxt.overflow = (count_r == FULL);
          if (count_r != FULL) begin
            count_nxt = count_r + 1'b1;
          end
        end
        olcr_pkg::ACT_QUERY: begin
          busy_nxt = 1'b1;
          op_nxt   = in_item.operand_value;
          mode_nxt = olcr_pkg::CMP_EQ;
          rm_nxt   = 1'b0;
        end
        olcr_pkg::ACT_REMOVE: begin
          busy_nxt = 1'b1;
          op_nxt   = in_item.operand_value;
          mode_nxt = in_item.compare_mode;
          rm_nxt   = 1'b1;
        end
        default: begin
          out_strobe_nxt = 1'b1;
        end
      endcase
    end else if (tk[DEPTH]) begin
      busy_nxt         = 1'b0;
      out_strobe_nxt   = 1'b1;
      out_item_nxt.hit = fd[DEPTH];
      if (rm_r && fd[DEPTH]) begin
        count_nxt = count_r - 1'b1;
      end
    end
    out_item_nxt.entry_count = 5'(count_nxt);
    out_item_nxt.is_empty    = (count_nxt == '0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Operand and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mode_r     <= mode_nxt;
    rm_r       <= rm_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `OLCR_ASSERT(a_count_bound, count_r <= FULL, "entry count exceeds depth")
  `OLCR_ASSERT_IMP(a_scan_done_strobe, $fell(busy_r), out_strobe_r,
                   "scan ended without a result")
  `OLCR_ASSERT(a_quick_result,
               (start && !busy_r && in_item.action != olcr_pkg::ACT_QUERY &&
                in_item.action != olcr_pkg::ACT_REMOVE) |=> out_strobe_r,
               "insert or unused action gave no result next cycle")
  `OLCR_ASSERT_IMP(a_remove_count, out_strobe_r && out_item_r.hit && rm_r && $fell(busy_r),
                   count_r == CW'($past(count_r) - 1'b1),
                   "removal hit did not drop the count by one")

endmodule
